// ----- hdl/calib_table_interpolator_macros.svh -----
// ----------------------------------------------------------------------------
// calib_table_interpolator assertion macros
// clocked assertion helpers shared by the interpolator rtl
// ----------------------------------------------------------------------------
`ifndef CALIB_TABLE_INTERPOLATOR_MACROS_SVH
`define CALIB_TABLE_INTERPOLATOR_MACROS_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define CTI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// condition that must never be seen outside reset
`define CTI_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define CTI_ASSERT(lbl, prop, msg)
`define CTI_NEVER(lbl, cond, msg)
`endif

`endif

// ----- hdl/cti_pkg.sv -----
// ----------------------------------------------------------------------------
// cti_pkg
// constants, widths and calibration rom of the table interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package cti_pkg;

    localparam int POINTS    = 41;
    localparam int FRAC_BITS = 4;

    localparam int IN_W      = 20;
    localparam int MASS_W    = 16;
    localparam int SUM_W     = 16;
    localparam int ENTRY_W   = SUM_W + MASS_W;
    localparam int ADDR_W    = $clog2(POINTS);

    // working widths
    localparam int CMP_W     = ((IN_W > SUM_W + FRAC_BITS) ? IN_W : SUM_W + FRAC_BITS) + 1;
    localparam int DIFF_W    = IN_W;
    localparam int NUM_W     = DIFF_W + MASS_W;
    localparam int Y1_W      = MASS_W + FRAC_BITS;
    localparam int Y_W       = NUM_W + 2;
    localparam int DIV_STEPS = NUM_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POINTS - 1);
    localparam logic [MASS_W-1:0] MAX_MASS_RST = 16'd40000;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    typedef struct packed {
        logic [MASS_W-1:0] rem;
        logic [NUM_W-1:0]  quo;
    } t_div;

    // calibration pairs: whole sum in the upper half, whole grams in the lower
    localparam logic [ENTRY_W-1:0] CALIB_ROM [POINTS] = '{
        {16'd11,   16'd0},    {16'd50,   16'd50},   {16'd85,   16'd100},
        {16'd132,  16'd150},  {16'd174,  16'd200},  {16'd216,  16'd250},
        {16'd272,  16'd300},  {16'd330,  16'd350},  {16'd408,  16'd400},
        {16'd476,  16'd450},  {16'd543,  16'd500},  {16'd577,  16'd550},
        {16'd631,  16'd600},  {16'd713,  16'd650},  {16'd767,  16'd700},
        {16'd843,  16'd750},  {16'd913,  16'd800},  {16'd974,  16'd850},
        {16'd1040, 16'd900},  {16'd1124, 16'd950},  {16'd1171, 16'd1000},
        {16'd1238, 16'd1050}, {16'd1276, 16'd1100}, {16'd1345, 16'd1150},
        {16'd1415, 16'd1200}, {16'd1487, 16'd1250}, {16'd1549, 16'd1300},
        {16'd1615, 16'd1350}, {16'd1689, 16'd1400}, {16'd1746, 16'd1450},
        {16'd1804, 16'd1500}, {16'd1847, 16'd1550}, {16'd1896, 16'd1600},
        {16'd1945, 16'd1650}, {16'd2005, 16'd1700}, {16'd2066, 16'd1750},
        {16'd2103, 16'd1800}, {16'd2162, 16'd1850}, {16'd2220, 16'd1900},
        {16'd2272, 16'd1950}, {16'd2316, 16'd2000}
    };

endpackage

`default_nettype wire

// ----- hdl/calib_table_interpolator.sv -----
// ----------------------------------------------------------------------------
// calib_table_interpolator
// load-cell reading to mass through a piecewise linear calibration table
// ----------------------------------------------------------------------------
// usage
//   input channel  : i_in_valid / o_in_ready carry i_reading_sum, a signed
//                    reading with 4 fraction bits; one transfer per item
//   output channel : o_out_valid / i_out_ready carry o_mass in 1/16 gram,
//                    clamped to max_mass; exactly one result per item
//   config channel : i_cfg_valid / o_cfg_ready write max_mass, always ready
//   sequencing     : the table walk reads one rom entry per cycle (up to
//                    41), then a multiply state, a 2-bit-per-cycle divider
//                    and a done state; non-positive readings go straight
//                    to done, readings at or below the first point leave the
//                    walk at its first entry
//   throughput     : one item at a time; the next input is taken once the
//                    result is in the output register
//   reset          : a low i_rst_n at a clock edge clears the sequencer and
//                    the output valid and sets max_mass to 40000; the rom
//                    needs no fill
//   stall          : a result waiting on i_out_ready holds; a finished item
//                    behind it waits in the done state until the slot frees
// ----------------------------------------------------------------------------
`default_nettype none
`include "calib_table_interpolator_macros.svh"

module calib_table_interpolator
    import cti_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // reading input
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic signed [IN_W-1:0]   i_reading_sum,
    // mass output
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [MASS_W-1:0]             o_mass,
    // max_mass write
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [MASS_W-1:0]        i_cfg_data
);

    // control registers
    logic [2:0]               r_state, n_state;
    logic [ADDR_W-1:0]        r_raddr, n_raddr;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_out_valid;
    logic [MASS_W-1:0]        r_max_mass;

    // datapath registers
    logic [ENTRY_W-1:0]       r_rom_q;
    logic [ENTRY_W-1:0]       r_prev;
    logic signed [IN_W-1:0]   r_x;
    logic [DIFF_W-1:0]        r_diff;
    logic [MASS_W-1:0]        r_dymag;
    logic                     r_neg;
    logic [MASS_W-1:0]        r_dx;
    logic [Y1_W-1:0]          r_y1;
    logic [NUM_W-1:0]         r_quo;
    logic [MASS_W-1:0]        r_rem;
    logic [MASS_W-1:0]        r_mass;

    // walk compare and segment setup
    logic signed [CMP_W-1:0]  x_ext, cur_x, prev_x, seg_diff;
    logic [SUM_W-1:0]         cur_sum, prev_sum;
    logic [MASS_W-1:0]        cur_mass, prev_mass;
    logic                     hit;
    logic [SUM_W:0]           seg_dx;
    logic [MASS_W:0]          seg_dy;
    logic                     dx_bad;

    // divider and final sum
    t_div                     div_in, div_mid, div_out;
    logic signed [Y_W-1:0]    y_base, y_q, y_sum;
    logic [MASS_W-1:0]        y_clamped;

    logic                     in_xfer, out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_mass      = r_mass;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // rom entry at r_raddr is in r_rom_q, previous entry in r_prev
    assign cur_sum   = r_rom_q[ENTRY_W-1:MASS_W];
    assign cur_mass  = r_rom_q[MASS_W-1:0];
    assign prev_sum  = r_prev[ENTRY_W-1:MASS_W];
    assign prev_mass = r_prev[MASS_W-1:0];

    assign x_ext    = CMP_W'(r_x);
    assign cur_x    = CMP_W'(cur_sum) << FRAC_BITS;
    assign prev_x   = CMP_W'(prev_sum) << FRAC_BITS;
    assign hit      = (x_ext <= cur_x);
    assign seg_diff = x_ext - prev_x;
    assign seg_dx   = {1'b0, cur_sum} - {1'b0, prev_sum};
    assign seg_dy   = {1'b0, cur_mass} - {1'b0, prev_mass};
    // a segment of zero or negative width gives its left mass
    assign dx_bad   = seg_dx[SUM_W] || (seg_dx == '0);

    function automatic t_div div_step(t_div s, logic [MASS_W-1:0] d);
        logic [MASS_W:0] t;
        t_div            r;
        t     = {s.rem, s.quo[NUM_W-1]};
        r.quo = {s.quo[NUM_W-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
            r.rem    = MASS_W'(t - {1'b0, d});
            r.quo[0] = 1'b1;
        end else begin
            r.rem    = t[MASS_W-1:0];
        end
        return r;
    endfunction

    // two quotient bits per cycle
    assign div_in.rem = r_rem;
    assign div_in.quo = r_quo;
    assign div_mid    = div_step(div_in, r_dx);
    assign div_out    = div_step(div_mid, r_dx);

    // y = y1 +/- |num| / dx, then clamp to [0, max_mass]
    always_comb begin
        y_base = Y_W'(r_y1);
        y_q    = Y_W'(r_quo);
        y_sum  = r_neg ? (y_base - y_q) : (y_base + y_q);
        if (y_sum[Y_W-1]) begin
            y_clamped = '0;
        end else if (y_sum > Y_W'(r_max_mass)) begin
            y_clamped = r_max_mass;
        end else begin
            y_clamped = y_sum[MASS_W-1:0];
        end
    end

    // sequencer next state and rom address
    always_comb begin
        n_state = r_state;
        n_raddr = r_raddr;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_raddr = '0;
                    n_state = (i_reading_sum <= 0) ? S_DONE : S_WALK;
                end
            end
            S_WALK: begin
                if (r_raddr == '0) begin
                    if (hit) begin
                        n_state = S_DONE;
                    end else begin
                        n_raddr = r_raddr + 1'b1;
                    end
                end else if (hit || (r_raddr == LAST_ADDR)) begin
                    n_state = dx_bad ? S_DONE : S_MUL;
                end else begin
                    n_raddr = r_raddr + 1'b1;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // calibration rom, one registered read per cycle
    always_ff @(posedge i_clk) begin
        r_rom_q <= CALIB_ROM[n_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_raddr     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_max_mass  <= MAX_MASS_RST;
        end else begin
            r_state <= n_state;
            r_raddr <= n_raddr;
            if (r_state == S_MUL) begin
                r_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_mass <= i_cfg_data;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    r_x   <= i_reading_sum;
                    // non-positive reading gives zero mass
                    r_y1  <= '0;
                    r_quo <= '0;
                    r_neg <= 1'b0;
                end
            end
            S_WALK: begin
                r_prev <= r_rom_q;
                if (r_raddr == '0) begin
                    // at or below the first point: first mass
                    r_y1  <= Y1_W'(cur_mass) << FRAC_BITS;
                    r_quo <= '0;
                    r_neg <= 1'b0;
                end else begin
                    r_y1    <= Y1_W'(prev_mass) << FRAC_BITS;
                    r_quo   <= '0;
                    r_diff  <= DIFF_W'(seg_diff);
                    r_dx    <= seg_dx[SUM_W-1:0];
                    r_neg   <= seg_dy[MASS_W];
                    r_dymag <= seg_dy[MASS_W] ? MASS_W'(-seg_dy) : seg_dy[MASS_W-1:0];
                end
            end
            S_MUL: begin
                r_quo <= NUM_W'(r_diff) * NUM_W'(r_dymag);
                r_rem <= '0;
            end
            S_DIV: begin
                r_quo <= div_out.quo;
                r_rem <= div_out.rem;
            end
            S_DONE: begin
                if (out_free) begin
                    r_mass <= y_clamped;
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    // checks
    `CTI_ASSERT(a_raddr_range, r_raddr <= LAST_ADDR, "rom address beyond last point")
    `CTI_NEVER(a_div_zero, (r_state == S_DIV) && (r_dx == '0), "divide by zero width segment")
    `CTI_ASSERT(a_done_loads, ((r_state == S_DONE) && out_free) |=> (r_out_valid && (r_state == S_IDLE)), "finished item not presented")
    `CTI_NEVER(a_busy_ready, o_in_ready && (r_state != S_IDLE), "input taken while busy")

endmodule

`default_nettype wire

// ----- test/calib_table_interpolator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calib_table_interpolator_tb
// self-checking bench for the load-cell calibration interpolator
// ----------------------------------------------------------------------------
// readings are queued by the sequence below and offered by a clocked driver.
// each accepted reading is run through a local piecewise linear predictor
// (own copy of the calibration pairs and of max_mass) and the expected mass
// is queued. a clocked monitor pops and compares on every output transfer.
// max_mass is rewritten between phases, only once the block has drained.
// both sides idle at random; one phase holds the output off for a long
// stretch so the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module calib_table_interpolator_tb;
    import cti_pkg::*;

    localparam int                CYCLE_LIMIT    = 1_200_000;
    localparam int                SETTLE_CYCLES  = 80;   // a bit over worst latency
    localparam int                HOLD_CYCLES    = 600;  // long output back-pressure
    localparam logic [MASS_W-1:0] MASS_LIMIT_RST = 16'd40000;
    localparam int                GRAM_STEP      = 50;   // mass of point i is 50 * i grams

    // whole calibration sums, one per point, strictly increasing
    localparam int CAL_SUM [POINTS] = '{
        11,   50,   85,   132,  174,  216,  272,  330,  408,  476,  543,
        577,  631,  713,  767,  843,  913,  974,  1040, 1124, 1171, 1238,
        1276, 1345, 1415, 1487, 1549, 1615, 1689, 1746, 1804, 1847, 1896,
        1945, 2005, 2066, 2103, 2162, 2220, 2272, 2316
    };

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // reading channel
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_ready;
    logic signed [IN_W-1:0] i_reading_sum = '0;

    // mass channel
    logic                   o_out_valid;
    logic                   i_out_ready   = 1'b0;
    logic [MASS_W-1:0]      o_mass;

    // max_mass write channel
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [MASS_W-1:0]      i_cfg_data    = '0;

    // predictor copy of the register, updated at each register transfer
    logic [MASS_W-1:0]      mass_limit    = MASS_LIMIT_RST;

    // readings waiting to be offered, and masses waiting to come out
    logic signed [IN_W-1:0] reading_queue [$];
    logic [MASS_W-1:0]      mass_expect   [$];

    int  readings_queued   = 0;
    int  readings_accepted = 0;
    int  err_count         = 0;
    int  cycle_cnt         = 0;

    // idle knobs per phase
    bit  tx_idle = 1'b0;
    bit  rx_idle = 1'b0;
    int  tx_gap  = 0;
    int  rx_gap  = 0;

    // long output hold-off, requested by the sequence, counted in its own process
    int  rx_hold_req  = 0;
    int  rx_hold_seen = 0;
    int  rx_hold_left = 0;

    always #4 i_clk = ~i_clk;

    calib_table_interpolator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_reading_sum (i_reading_sum),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_mass        (o_mass),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // piecewise linear mass from a reading, truncating division, clamped
    function automatic logic [MASS_W-1:0] predict_mass(
        input logic signed [IN_W-1:0] rd,
        input logic [MASS_W-1:0]      limit
    );
        longint x;
        longint scale;
        longint x1;
        longint y1;
        longint dx;
        longint dy;
        longint num;
        longint y;
        int     seg;
        x     = longint'(rd);
        scale = longint'(1) << FRAC_BITS;
        seg   = POINTS - 2;
        if (x <= 0) begin
            // non-positive reading weighs nothing
            y = 0;
        end else if (x <= longint'(CAL_SUM[0]) * scale) begin
            // at or below the first point: first mass
            y = 0;
        end else begin
            // first segment whose right end reaches x; past the table the
            // last segment is extended
            for (int i = POINTS - 2; i >= 0; i--) begin
                if (x <= longint'(CAL_SUM[i+1]) * scale)
                    seg = i;
            end
            x1 = longint'(CAL_SUM[seg]) * scale;
            y1 = longint'(GRAM_STEP * seg) * scale;
            dx = longint'(CAL_SUM[seg+1] - CAL_SUM[seg]);
            dy = longint'(GRAM_STEP);
            if (dx <= 0) begin
                // zero-width segment keeps its left mass
                y = y1;
            end else begin
                num = (x - x1) * dy;
                if (num < 0)
                    y = y1 - ((-num) / dx);
                else
                    y = y1 + num / dx;
            end
        end
        if (y < 0)
            y = 0;
        if (y > longint'(limit))
            y = longint'(limit);
        return y[MASS_W-1:0];
    endfunction

    // random reading, weighted toward the table span and its breakpoints
    function automatic logic signed [IN_W-1:0] random_reading();
        int pt;
        case ($urandom_range(0, 7))
            0: return IN_W'($urandom());
            1: return IN_W'(-int'($urandom_range(1, 524288)));
            5: begin
                pt = $urandom_range(0, POINTS - 1);
                return IN_W'((CAL_SUM[pt] << FRAC_BITS) + int'($urandom_range(0, 4)) - 2);
            end
            6: return IN_W'($urandom_range(37056, 524287));
            7: return IN_W'($urandom_range(0, 200));
            default: return IN_W'($urandom_range(1, 37056));
        endcase
    endfunction

    // gap before the next offer: mostly none, some short, a few long
    function automatic int draw_gap(input bit active);
        int r;
        if (!active)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // reading driver: records the expectation at each transfer, then offers
    // the next queued reading unless a gap is pending
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_reading_sum <= '0;
            tx_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                mass_expect.push_back(predict_mass(i_reading_sum, mass_limit));
                readings_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (reading_queue.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_reading_sum <= reading_queue.pop_front();
                    tx_gap = draw_gap(tx_idle);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long hold-off counter for the mass side
    always @(posedge i_clk) begin
        if (rx_hold_req != rx_hold_seen) begin
            rx_hold_seen <= rx_hold_req;
            rx_hold_left <= HOLD_CYCLES;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // mass monitor: compare each transfer against the oldest expectation,
    // then decide ready for the next cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (mass_expect.size() == 0) begin
                    $error("mass: unexpected result %0d with nothing expected", o_mass);
                    err_count++;
                end else if (o_mass !== mass_expect[0]) begin
                    $error("mass: expected %0d actual %0d", mass_expect[0], o_mass);
                    err_count++;
                    void'(mass_expect.pop_front());
                end else begin
                    void'(mass_expect.pop_front());
                end
            end
            if (rx_hold_left > 0) begin
                i_out_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                i_out_ready <= 1'b0;
                rx_gap <= rx_gap - 1;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rx_gap <= draw_gap(rx_idle);
            end
        end
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("calib_table_interpolator_tb: FAIL");
            $finish;
        end
    end

    // wait for every queued reading to transfer and every mass to come back,
    // then let the sequencer settle
    task automatic drain();
        while (!(readings_accepted == readings_queued && mass_expect.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_reading(input logic signed [IN_W-1:0] rd);
        reading_queue.push_back(rd);
        readings_queued++;
    endtask

    // max_mass write, only called with the block drained
    task automatic write_max_mass(input logic [MASS_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        mass_limit = value;
        i_cfg_valid <= 1'b0;
    endtask

    // one setting of max_mass with its own idle pattern
    task automatic run_phase(
        input logic [MASS_W-1:0] limit,
        input int                n,
        input bit                tx_on,
        input bit                rx_on,
        input bit                hold
    );
        write_max_mass(limit);
        tx_idle = tx_on;
        rx_idle = rx_on;
        for (int k = 0; k < n; k++)
            queue_reading(random_reading());
        // back up the output while the driver keeps offering
        if (hold)
            rx_hold_req <= rx_hold_req + 1;
        drain();
    endtask

    initial begin
        // directed readings: sign extremes, first point, breakpoints,
        // the last point, extrapolation and the clamp edge at 40000
        int directed [] = '{
            0, 1, -1, -524288, 524287,
            175, 176, 177, 800, 801, 9999,
            36352, 37055, 37056, 37057,
            44095, 44096, 44097,
            'h55555, 'hAAAAA
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value of max_mass, no idling at first
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        foreach (directed[k])
            queue_reading(IN_W'(directed[k]));
        drain();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (int k = 0; k < 120; k++)
            queue_reading(random_reading());
        drain();

        run_phase(16'hFFFF, 220, 1'b1, 1'b1, 1'b0);
        run_phase(16'd0, 60, 1'b1, 1'b0, 1'b0);
        run_phase(16'd1, 60, 1'b0, 1'b1, 1'b0);
        run_phase(MASS_W'($urandom_range(2, 65534)), 200, 1'b1, 1'b1, 1'b0);
        run_phase(16'hFFFF, 250, 1'b0, 1'b0, 1'b1);
        run_phase(16'd32000, 200, 1'b1, 1'b1, 1'b0);
        run_phase(MASS_LIMIT_RST, 250, 1'b0, 1'b1, 1'b0);

        if (err_count == 0) begin
            $display("calib_table_interpolator_tb: PASS");
        end else begin
            $display("calib_table_interpolator_tb: FAIL");
        end
        $finish;
    end

endmodule
